>>> rtl/core/length_prefixed_message_deframer_top_assert.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shorthand for the concurrent checks of the deframer's port checker.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPMD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Deframer check failed.");

// The consequent must hold in the cycle after the antecedent.
`define LPMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Deframer check failed.");

`endif

>>> rtl/core/lpmd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Transaction types, internal stage types and the parser phase encoding.
// ----------------------------------------------------------------------------
package lpmd_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_packet;
   } req_type;

   typedef struct packed {
      logic [7:0] message_type;
      logic [7:0] payload_byte;
      logic       has_data;
      logic       end_of_message;
      logic       truncated;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } stage_type;

   typedef struct packed {
      logic    emit;
      rsp_type item;
   } result_type;

   typedef enum logic [1:0] {
      PH_LEN_LO,
      PH_LEN_HI,
      PH_TYPE,
      PH_DATA
   } phase_type;

endpackage

>>> rtl/core/lpmd_in_reg.sv
// ----------------------------------------------------------------------------
// Deframer input register
// Holds one accepted request transaction until the parser takes it.
// ----------------------------------------------------------------------------
module lpmd_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lpmd_pkg::req_type  req_data,
   input  logic               take,
   output lpmd_pkg::stage_type stage
);

   logic              valid_ff;
   logic              valid_in;
   lpmd_pkg::req_type data_ff;
   lpmd_pkg::req_type data_in;

   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = req_ready ? req_valid : valid_ff;
      data_in  = (req_valid && req_ready) ? req_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = data_ff;

endmodule

>>> rtl/core/lpmd_parser.sv
// ----------------------------------------------------------------------------
// Deframer parser
// Walks the length header, type byte and payload of each message, one byte
// per cycle while out_free is high, and forms at most one result per byte.
// ----------------------------------------------------------------------------
module lpmd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  lpmd_pkg::stage_type  stage,
   input  logic                 out_free,
   output logic                 take,
   output lpmd_pkg::result_type result
);

   lpmd_pkg::phase_type phase_ff;
   lpmd_pkg::phase_type phase_in;
   logic [7:0]          length_low_ff;
   logic [7:0]          length_low_in;
   logic [15:0]         bytes_remaining_ff;
   logic [15:0]         bytes_remaining_in;
   logic [7:0]          current_type_ff;
   logic [7:0]          current_type_in;
   logic [15:0]         bytes_dec;
   logic [15:0]         header_len;
   logic                dec_zero;
   logic [7:0]          byte_value;
   logic                eop;

   assign take       = stage.valid && out_free;
   assign byte_value = stage.item.data_byte;
   assign eop        = stage.item.end_of_packet;
   assign bytes_dec  = bytes_remaining_ff - 16'd1;
   assign dec_zero   = (bytes_dec == 16'd0);
   assign header_len = {byte_value, length_low_ff};

   always_comb begin
      phase_in           = phase_ff;
      length_low_in      = length_low_ff;
      bytes_remaining_in = bytes_remaining_ff;
      current_type_in    = current_type_ff;
      if (take) begin
         case (phase_ff)
            lpmd_pkg::PH_LEN_LO: begin
               length_low_in = byte_value;
               phase_in      = lpmd_pkg::PH_LEN_HI;
            end
            lpmd_pkg::PH_LEN_HI: begin
               bytes_remaining_in = header_len;
               phase_in = (header_len == 16'd0) ? lpmd_pkg::PH_LEN_LO : lpmd_pkg::PH_TYPE;
            end
            lpmd_pkg::PH_TYPE: begin
               current_type_in    = byte_value;
               bytes_remaining_in = bytes_dec;
               phase_in = dec_zero ? lpmd_pkg::PH_LEN_LO : lpmd_pkg::PH_DATA;
            end
            lpmd_pkg::PH_DATA: begin
               bytes_remaining_in = bytes_dec;
               if (dec_zero) begin
                  phase_in = lpmd_pkg::PH_LEN_LO;
               end
            end
            default: begin
               phase_in = lpmd_pkg::PH_LEN_LO;
            end
         endcase
         if (eop) begin
            phase_in = lpmd_pkg::PH_LEN_LO;
         end
      end
   end

   always_comb begin
      result.emit                = 1'b0;
      result.item.message_type   = current_type_ff;
      result.item.payload_byte   = 8'd0;
      result.item.has_data       = 1'b0;
      result.item.end_of_message = 1'b0;
      result.item.truncated      = 1'b0;
      case (phase_ff)
         lpmd_pkg::PH_TYPE: begin
            result.emit                = dec_zero || eop;
            result.item.message_type   = byte_value;
            result.item.end_of_message = 1'b1;
            result.item.truncated      = !dec_zero;
         end
         lpmd_pkg::PH_DATA: begin
            result.emit                = 1'b1;
            result.item.payload_byte   = byte_value;
            result.item.has_data       = 1'b1;
            result.item.end_of_message = dec_zero || eop;
            result.item.truncated      = eop && !dec_zero;
         end
         default: begin
            result.emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= lpmd_pkg::PH_LEN_LO;
         length_low_ff      <= 8'd0;
         bytes_remaining_ff <= 16'd0;
         current_type_ff    <= 8'd0;
      end else begin
         phase_ff           <= phase_in;
         length_low_ff      <= length_low_in;
         bytes_remaining_ff <= bytes_remaining_in;
         current_type_ff    <= current_type_in;
      end
   end

endmodule

>>> rtl/core/lpmd_out_reg.sv
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result transaction until the downstream side accepts it.
// ----------------------------------------------------------------------------
module lpmd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  lpmd_pkg::result_type result,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lpmd_pkg::rsp_type    rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   lpmd_pkg::rsp_type data_ff;
   lpmd_pkg::rsp_type data_in;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      if (take) begin
         valid_in = result.emit;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
      data_in = (take && result.emit) ? result.item : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> rtl/core/length_prefixed_message_deframer_top.sv
// The deframer takes one datagram byte per cycle and returns payload bytes
// tagged with their message type. It keeps that rate of one byte per cycle
// for as long as the result side keeps taking results. A byte's result
// reaches the result port through the input register and the result
// register: the byte waits in the input register, and the parser writes
// its result into the result register. A result that the receiver has not
// taken holds the parser and, through it, the input register.
// ----------------------------------------------------------------------------
// Length-prefixed message deframer
// Splits datagrams into messages with a 16-bit little-endian length header
// and a type byte, and tags each payload byte with its message type.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpmd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpmd_pkg::rsp_type rsp_data
);

   lpmd_pkg::stage_type  stage;
   lpmd_pkg::result_type result;
   logic                 take;
   logic                 out_free;

   lpmd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .take      (take),
      .stage     (stage)
   );

   lpmd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .out_free (out_free),
      .take     (take),
      .result   (result)
   );

   lpmd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/lpmd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Checks result transactions seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "length_prefixed_message_deframer_top_assert.svh"

module lpmd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lpmd_pkg::rsp_type rsp_data
);

   `LPMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))
   `LPMD_ASSERT_SAME(a_empty_ends, clock, reset, rsp_valid && !rsp_data.has_data,
      rsp_data.payload_byte == 8'd0 && rsp_data.end_of_message)
   `LPMD_ASSERT_SAME(a_trunc_ends, clock, reset, rsp_valid && rsp_data.truncated,
      rsp_data.end_of_message)
   `LPMD_ASSERT_SAME(a_reset_idle, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind length_prefixed_message_deframer_top lpmd_checker u_lpmd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
